### src/rjp_pkg.sv
package rjp_pkg;

  // Configuration register indexes
  localparam logic CFG_MAX_PAYLOAD = 1'b0;
  localparam logic CFG_SSRC        = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  // RTP and JPEG header constants
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [6:0] RTP_PT_JPEG      = 7'd26;
  localparam logic [7:0] Q_FIRST          = 8'd128;
  localparam logic [7:0] Q_LATER          = 8'd96;
  localparam logic [4:0] HDR_LEN_PLAIN    = 5'd20;
  localparam logic [4:0] HDR_LEN_QUANT    = 5'd24;

  // Snapshot of one accepted word: everything needed to stream its results
  typedef struct packed {
    logic        has_hdr;
    logic        quant;
    logic        marker;
    logic        drop;
    logic        pkt_end;
    logic [7:0]  data;
    logic [15:0] seq;
    logic [23:0] offset;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [7:0]  w8;
    logic [7:0]  h8;
  } job_t;

endpackage

### src/rtp_jpeg_packetizer_core.sv
// RTP/JPEG packetizer core.
// Input channel (in_valid_i/in_ready_o): one word per byte of a frame. A frame
// is TABLE_BYTES quantization table words (req_type_i = 0) followed by
// frame_bytes_i frame data words (req_type_i = 1). Frame length, timestamp and
// image size ride along with every word.
// Output channel (out_valid_o/out_ready_i): one packet byte per word, with
// packet_start_o/packet_end_o framing, frame_dropped_o on the single word that
// flags a rejected frame, and run_last_o on the last word caused by an input
// word. Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 = max payload bytes, 1 = SSRC); write only while the block is idle.
// Accepted words pass through the job register, then the output register.
// Throughput: one input word per cycle while the output is not stalled, except
// a word that opens a packet, which holds the job register while its 20 header
// bytes and payload byte stream out (24 header bytes on the first packet of a
// frame, which adds the quant header); the header byte counter tracks them.
// Words that cause no result never occupy the output stage.
// Reset clears the sequence number and frame state, sets max payload to 1024
// and SSRC to 0. When the receiver stalls, the output register holds its word
// and a single job register behind it keeps the input flowing until it fills.
module rtp_jpeg_packetizer_core #(
  parameter int TABLE_BYTES   = 128,
  parameter int MAX_DIMENSION = 2040
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] frame_bytes_i,
  input  logic [31:0] frame_timestamp_i,
  input  logic [11:0] width_pixels_i,
  input  logic [11:0] height_pixels_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        frame_dropped_o,
  output logic        run_last_o
);

  localparam int TW = $clog2(TABLE_BYTES + 1);

  // Configuration registers
  logic [15:0] max_pay_q;
  logic [31:0] ssrc_q;

  // Frame state
  logic [15:0] seq_q, seq_d;
  logic [23:0] off_q, off_d;
  logic [15:0] bip_q, bip_d;
  logic [TW-1:0] tbl_q, tbl_d;
  logic        fvalid_q, fvalid_d;

  // Job register and header burst counter
  rjp_pkg::job_t job_q, job_n;
  logic        job_valid_q, job_valid_d;
  logic        emit_n;
  logic [4:0]  hdr_cnt_q;
  logic [4:0]  job_len;
  logic        job_last;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_start_q, out_start_d;
  logic        out_end_q, out_end_d;
  logic        out_drop_q, out_drop_d;
  logic        out_last_q;

  logic out_load, in_fire;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pay_q <= rjp_pkg::MAX_PAYLOAD_RST;
      ssrc_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rjp_pkg::CFG_MAX_PAYLOAD: max_pay_q <= cfg_wdata_i[15:0];
        rjp_pkg::CFG_SSRC:        ssrc_q    <= cfg_wdata_i;
        default:                  ssrc_q    <= ssrc_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register takes a word whenever it is empty or being
  // drained; input enters while no job is held or as its last result moves out.
  // ---------------------------------------------------------------------------
  assign job_len   = job_q.has_hdr ? (job_q.quant ? rjp_pkg::HDR_LEN_QUANT
                                                  : rjp_pkg::HDR_LEN_PLAIN) : 5'd0;
  assign job_last  = (hdr_cnt_q == job_len);
  assign out_load  = job_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !job_valid_q || (out_load && job_last);
  assign in_fire   = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Frame state update, all in one pass on the incoming word
  // ---------------------------------------------------------------------------
  logic        idle, bad_frame, pend, fend, last_pkt, first_marker;
  logic [15:0] mp;
  logic [24:0] off_inc;
  logic [16:0] bip_inc;
  logic [TW:0] tbl_inc;
  logic [23:0] remain;

  assign idle      = (tbl_q == '0) && (off_q == '0);
  assign mp        = (max_pay_q == '0) ? 16'd1 : max_pay_q;
  assign bad_frame = (frame_bytes_i < 24'd2)
                  || (width_pixels_i == '0) || (width_pixels_i > 12'(MAX_DIMENSION))
                  || (height_pixels_i == '0) || (height_pixels_i > 12'(MAX_DIMENSION));
  assign off_inc   = {1'b0, off_q} + 25'd1;
  assign bip_inc   = {1'b0, bip_q} + 17'd1;
  assign tbl_inc   = {1'b0, tbl_q} + {{TW{1'b0}}, 1'b1};
  assign fend      = off_inc >= {1'b0, frame_bytes_i};
  assign pend      = (bip_inc >= {1'b0, mp}) || fend;
  assign remain    = frame_bytes_i - off_q;
  assign last_pkt  = (frame_bytes_i <= off_q) || (remain <= {8'd0, mp});
  assign first_marker = frame_bytes_i <= {8'd0, mp};

  always_comb begin
    seq_d    = seq_q;
    off_d    = off_q;
    bip_d    = bip_q;
    tbl_d    = tbl_q;
    fvalid_d = fvalid_q;
    emit_n   = 1'b0;

    job_n         = '0;
    job_n.data    = data_byte_i;
    job_n.seq     = seq_q;
    job_n.offset  = off_q;
    job_n.ts      = frame_timestamp_i;
    job_n.ssrc    = ssrc_q;
    job_n.w8      = width_pixels_i[10:3];
    job_n.h8      = height_pixels_i[10:3];

    if (in_fire) begin
      if (idle) begin
        if (!req_type_i) begin
          tbl_d  = TW'(1);
          emit_n = 1'b1;
          if (bad_frame) begin
            fvalid_d   = 1'b0;
            job_n.drop = 1'b1;
          end else begin
            fvalid_d      = 1'b1;
            bip_d         = '0;
            job_n.has_hdr = 1'b1;
            job_n.quant   = 1'b1;
            job_n.marker  = first_marker;
            seq_d         = seq_q + 16'd1;
          end
        end
      end else if (tbl_q < TW'(TABLE_BYTES)) begin
        if (!req_type_i) begin
          tbl_d = tbl_inc[TW-1:0];
          if (fvalid_q) begin
            emit_n = 1'b1;
          end else if ((tbl_inc >= (TW+1)'(TABLE_BYTES)) && (frame_bytes_i == '0)) begin
            tbl_d = '0;
            off_d = '0;
            bip_d = '0;
          end
        end
      end else begin
        if (req_type_i) begin
          if (fvalid_q) begin
            emit_n        = 1'b1;
            job_n.pkt_end = pend;
            if ((bip_q == '0) && (off_q != '0)) begin
              job_n.has_hdr = 1'b1;
              job_n.marker  = last_pkt;
              seq_d         = seq_q + 16'd1;
            end
          end
          off_d = off_inc[23:0];
          bip_d = pend ? 16'd0 : bip_inc[15:0];
          if (fend) begin
            tbl_d    = '0;
            off_d    = '0;
            bip_d    = '0;
            fvalid_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= '0;
      off_q    <= '0;
      bip_q    <= '0;
      tbl_q    <= '0;
      fvalid_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      off_q    <= off_d;
      bip_q    <= bip_d;
      tbl_q    <= tbl_d;
      fvalid_q <= fvalid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Job register: hold the snapshot while its header burst streams out
  // ---------------------------------------------------------------------------
  always_comb begin
    if (in_fire) begin
      job_valid_d = emit_n;
    end else if (out_load && job_last) begin
      job_valid_d = 1'b0;
    end else begin
      job_valid_d = job_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      hdr_cnt_q   <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      if (out_load) begin
        hdr_cnt_q <= job_last ? 5'd0 : hdr_cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit_n) begin
      job_q <= job_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Result byte select: header bytes by position, then the payload word
  // ---------------------------------------------------------------------------
  always_comb begin
    out_start_d = job_q.has_hdr && (hdr_cnt_q == 5'd0);
    out_end_d   = 1'b0;
    out_drop_d  = 1'b0;
    if (job_last) begin
      out_byte_d = job_q.drop ? 8'd0 : job_q.data;
      out_end_d  = job_q.pkt_end;
      out_drop_d = job_q.drop;
    end else begin
      case (hdr_cnt_q)
        5'd0:    out_byte_d = rjp_pkg::RTP_VERSION_BYTE;
        5'd1:    out_byte_d = {job_q.marker, rjp_pkg::RTP_PT_JPEG};
        5'd2:    out_byte_d = job_q.seq[15:8];
        5'd3:    out_byte_d = job_q.seq[7:0];
        5'd4:    out_byte_d = job_q.ts[31:24];
        5'd5:    out_byte_d = job_q.ts[23:16];
        5'd6:    out_byte_d = job_q.ts[15:8];
        5'd7:    out_byte_d = job_q.ts[7:0];
        5'd8:    out_byte_d = job_q.ssrc[31:24];
        5'd9:    out_byte_d = job_q.ssrc[23:16];
        5'd10:   out_byte_d = job_q.ssrc[15:8];
        5'd11:   out_byte_d = job_q.ssrc[7:0];
        5'd13:   out_byte_d = job_q.offset[23:16];
        5'd14:   out_byte_d = job_q.offset[15:8];
        5'd15:   out_byte_d = job_q.offset[7:0];
        5'd17:   out_byte_d = job_q.quant ? rjp_pkg::Q_FIRST : rjp_pkg::Q_LATER;
        5'd18:   out_byte_d = job_q.w8;
        5'd19:   out_byte_d = job_q.h8;
        5'd23:   out_byte_d = 8'(TABLE_BYTES);
        default: out_byte_d = 8'd0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, advance on load
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q  <= out_byte_d;
      out_start_q <= out_start_d;
      out_end_q   <= out_end_d;
      out_drop_q  <= out_drop_d;
      out_last_q  <= job_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign packet_start_o  = out_start_q;
  assign packet_end_o    = out_end_q;
  assign frame_dropped_o = out_drop_q;
  assign run_last_o      = out_last_q;

endmodule

### src/rjp_checker.sv
module rjp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       packet_start_o,
  input logic       packet_end_o,
  input logic       frame_dropped_o,
  input logic       run_last_o
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(packet_start_o) && $stable(run_last_o))
    else $error("output word changed while stalled");

  // Every packet opens with the RTP version byte
  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_start_o |-> out_byte_o == 8'h80 && !run_last_o)
    else $error("packet start without version byte");

  // A drop flag is a lone, unframed zero word
  a_drop_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_dropped_o |-> run_last_o && !packet_start_o
      && !packet_end_o && out_byte_o == 8'd0)
    else $error("malformed drop word");

  // A packet ends on a payload word, which is always last of its input word
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> run_last_o)
    else $error("packet end inside a header burst");

endmodule

bind rtp_jpeg_packetizer_core rjp_checker u_rjp_checker (.*);
